[rtl/aag_pkg.sv]
package aag_pkg;

    localparam int RULE_W   = 32;
    localparam int KEY_W    = 64;
    localparam int PID_W    = 32;
    localparam int TIME_W   = 48;
    localparam int CAP_W    = 16;
    localparam int DSEC_W   = 12;
    localparam int REASON_W = 3;
    localparam int CMP_W    = 128;
    localparam int WIN_W    = 22;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int MS_PER_S = 1000;

    localparam int DEF_TENANT_SLOTS   = 32;
    localparam int DEF_ENDPOINT_SLOTS = 64;
    localparam int DEF_DEDUP_SLOTS    = 32;
    localparam int DEF_ROLL_MS        = 60000;

    localparam logic [CAP_W-1:0]  RST_GLOBAL_CAP   = 16'd0;
    localparam logic [CAP_W-1:0]  RST_TENANT_CAP   = 16'd60;
    localparam logic [CAP_W-1:0]  RST_ENDPOINT_CAP = 16'd0;
    localparam logic [DSEC_W-1:0] RST_DEDUP_SECS   = 12'd10;

    typedef enum logic [1:0] {
        REG_GLOBAL_CAP   = 2'd0,
        REG_TENANT_CAP   = 2'd1,
        REG_ENDPOINT_CAP = 2'd2,
        REG_DEDUP_SECS   = 2'd3
    } reg_idx_t;

    localparam logic [REASON_W-1:0] RSN_NONE     = 3'd0;
    localparam logic [REASON_W-1:0] RSN_GLOBAL   = 3'd1;
    localparam logic [REASON_W-1:0] RSN_TENANT   = 3'd2;
    localparam logic [REASON_W-1:0] RSN_ENDPOINT = 3'd3;
    localparam logic [REASON_W-1:0] RSN_DUP      = 3'd4;

    typedef struct packed {
        logic key_eq;
        logic start_zero;
        logic now_lt;
        logic span_ge;
    } match_t;

endpackage

[rtl/aag_if.sv]
interface aag_req_if;
    import aag_pkg::*;
    logic              valid;
    logic              ready;
    logic [RULE_W-1:0] rule_key;
    logic [KEY_W-1:0]  tenant_key;
    logic [KEY_W-1:0]  endpoint_key;
    logic [PID_W-1:0]  process_id;
    logic [TIME_W-1:0] now_ms;
    modport source (output valid, rule_key, tenant_key, endpoint_key, process_id, now_ms,
                    input ready);
    modport sink   (input valid, rule_key, tenant_key, endpoint_key, process_id, now_ms,
                    output ready);
endinterface

interface aag_res_if;
    import aag_pkg::*;
    logic                valid;
    logic                ready;
    logic                admitted;
    logic [REASON_W-1:0] block_reason;
    modport source (output valid, admitted, block_reason, input ready);
    modport sink   (input valid, admitted, block_reason, output ready);
endinterface

[rtl/aag_ram.sv]
module aag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/aag_match_unit.sv]
module aag_match_unit (
    input  logic [aag_pkg::CMP_W-1:0]  key_a,
    input  logic [aag_pkg::CMP_W-1:0]  key_b,
    input  logic [aag_pkg::TIME_W-1:0] now,
    input  logic [aag_pkg::TIME_W-1:0] start,
    input  logic [aag_pkg::WIN_W-1:0]  win,
    output aag_pkg::match_t            res
);
    import aag_pkg::*;

    logic [TIME_W-1:0] span;

    // span only matters when now is not below start
    assign span           = now - start;
    assign res.key_eq     = (key_a == key_b);
    assign res.start_zero = (start == '0);
    assign res.now_lt     = (now < start);
    assign res.span_ge    = (span >= {{(TIME_W - WIN_W){1'b0}}, win});
endmodule

[rtl/alert_admission_gate.sv]
// Alert admission gate. Each request (rule, tenant, endpoint, pid, time in ms)
// passes a global fixed-window cap, a per-tenant cap, a per-endpoint cap and
// duplicate suppression, in that order; the first failing check sets
// block_reason, and window rolls and slot allocations made before it stay.
// One request is handled at a time and req.ready is high only while idle.
// A request is taken in idle, then passes the global check, a read and
// compare step per slot plus an update step on each tenant or endpoint check
// that runs and a read and compare step per slot on the dedup check, where
// the slots read run up to and including a key hit, the whole table on a
// miss; an admitted request then passes a commit step, and the result is
// presented in done until res.ready is high. The slot scan dominates: one
// slot is read at a time from each table RAM through a single shared key
// and window compare unit. Tables reset to zero through per-slot valid bits,
// so there is no clearing pass.
// Registers on the APB port: 0x0 global_cap, 0x4 tenant_cap, 0x8
// endpoint_cap, 0xC dedup_seconds; write them only while no request is open.
module alert_admission_gate #(
    parameter int TENANT_SLOTS   = aag_pkg::DEF_TENANT_SLOTS,
    parameter int ENDPOINT_SLOTS = aag_pkg::DEF_ENDPOINT_SLOTS,
    parameter int DEDUP_SLOTS    = aag_pkg::DEF_DEDUP_SLOTS,
    parameter int ROLL_MS        = aag_pkg::DEF_ROLL_MS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    aag_req_if.sink                     req,
    aag_res_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aag_pkg::PADDR_W-1:0] paddr,
    input  logic [aag_pkg::PDATA_W-1:0] pwdata,
    output logic [aag_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import aag_pkg::*;

    localparam int TAW = (TENANT_SLOTS > 1) ? $clog2(TENANT_SLOTS) : 1;
    localparam int EAW = (ENDPOINT_SLOTS > 1) ? $clog2(ENDPOINT_SLOTS) : 1;
    localparam int DAW = (DEDUP_SLOTS > 1) ? $clog2(DEDUP_SLOTS) : 1;
    localparam int IW0 = (TAW > EAW) ? TAW : EAW;
    localparam int IW  = (IW0 > DAW) ? IW0 : DAW;
    localparam int SW  = KEY_W + TIME_W + CAP_W;
    localparam int DW  = RULE_W + PID_W + KEY_W + TIME_W;
    localparam logic [WIN_W-1:0] WIN_LEN = WIN_W'(ROLL_MS);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_GLOBAL = 12'b0000_0000_0010,
        S_T_RD   = 12'b0000_0000_0100,
        S_T_CMP  = 12'b0000_0000_1000,
        S_T_UPD  = 12'b0000_0001_0000,
        S_E_RD   = 12'b0000_0010_0000,
        S_E_CMP  = 12'b0000_0100_0000,
        S_E_UPD  = 12'b0000_1000_0000,
        S_D_RD   = 12'b0001_0000_0000,
        S_D_CMP  = 12'b0010_0000_0000,
        S_COMMIT = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    // latched request
    logic [RULE_W-1:0] rule_reg;
    logic [KEY_W-1:0]  tkey_reg, ekey_reg;
    logic [PID_W-1:0]  pid_reg;
    logic [TIME_W-1:0] now_reg;

    // configuration
    logic [CAP_W-1:0]  gcap_reg, tcap_reg, ecap_reg;
    logic [DSEC_W-1:0] dsec_reg;

    // global window
    logic [TIME_W-1:0] gstart_reg, gstart_next;
    logic [CAP_W-1:0]  gcount_reg, gcount_next;

    // table pointers and valid bits
    logic [TAW-1:0] tptr_reg, tptr_next;
    logic [EAW-1:0] eptr_reg, eptr_next;
    logic [DAW-1:0] dptr_reg, dptr_next;
    logic [TENANT_SLOTS-1:0]   tval_reg, tval_next;
    logic [ENDPOINT_SLOTS-1:0] evalid_reg, evalid_next;
    logic [DEDUP_SLOTS-1:0]    dval_reg, dval_next;
    logic trv_reg, erv_reg, drv_reg;

    // selected slot of each cap table
    logic [TAW-1:0]    tsel_reg, tsel_next;
    logic [EAW-1:0]    esel_reg, esel_next;
    logic [TIME_W-1:0] tstart_reg, tstart_next, estart_reg, estart_next;
    logic [CAP_W-1:0]  tcnt_reg, tcnt_next, ecnt_reg, ecnt_next;
    logic              tused_reg, tused_next, eused_reg, eused_next;
    logic [REASON_W-1:0] reason_reg, reason_next;

    // RAM ports
    logic           t_we, e_we, d_we;
    logic [TAW-1:0] t_waddr;
    logic [EAW-1:0] e_waddr;
    logic [DAW-1:0] d_waddr;
    logic [SW-1:0]  t_wdata, e_wdata, t_rdata, e_rdata, t_word, e_word;
    logic [DW-1:0]  d_wdata, d_rdata, d_word;

    // shared compare unit
    logic [CMP_W-1:0]  u_key_a, u_key_b;
    logic [TIME_W-1:0] u_start;
    logic [WIN_W-1:0]  u_win, dwin;
    match_t            u_res;
    logic              expired;

    logic t_en, e_en, d_en;
    logic cfg_wr;
    logic [TIME_W-1:0] nstart;
    logic [CAP_W-1:0]  ncnt;

    aag_ram #(.WIDTH(SW), .DEPTH(TENANT_SLOTS)) u_tram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(idx_reg[TAW-1:0]), .rdata(t_rdata)
    );
    aag_ram #(.WIDTH(SW), .DEPTH(ENDPOINT_SLOTS)) u_eram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(idx_reg[EAW-1:0]), .rdata(e_rdata)
    );
    aag_ram #(.WIDTH(DW), .DEPTH(DEDUP_SLOTS)) u_dram (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(idx_reg[DAW-1:0]), .rdata(d_rdata)
    );

    aag_match_unit u_match (
        .key_a(u_key_a), .key_b(u_key_b), .now(now_reg),
        .start(u_start), .win(u_win), .res(u_res)
    );

    // a slot never written reads as all zero
    assign t_word = trv_reg ? t_rdata : '0;
    assign e_word = erv_reg ? e_rdata : '0;
    assign d_word = drv_reg ? d_rdata : '0;

    assign dwin    = {{(WIN_W - DSEC_W){1'b0}}, dsec_reg} * WIN_W'(MS_PER_S);
    assign expired = u_res.start_zero || u_res.now_lt || u_res.span_ge;

    assign t_en = (tcap_reg != '0) && (now_reg != '0);
    assign e_en = (ecap_reg != '0) && (now_reg != '0);
    assign d_en = (dsec_reg != '0) && (now_reg != '0);

    // feed the shared unit from whichever step is running
    always_comb
    begin
        u_key_a = '0;
        u_key_b = '0;
        u_start = '0;
        u_win   = WIN_LEN;
        unique case (state_reg)
            S_GLOBAL:
            begin
                u_start = gstart_reg;
            end
            S_T_CMP:
            begin
                u_key_a = {{(CMP_W - KEY_W){1'b0}}, tkey_reg};
                u_key_b = {{(CMP_W - KEY_W){1'b0}}, t_word[SW-1 -: KEY_W]};
            end
            S_T_UPD:
            begin
                u_start = tstart_reg;
            end
            S_E_CMP:
            begin
                u_key_a = {{(CMP_W - KEY_W){1'b0}}, ekey_reg};
                u_key_b = {{(CMP_W - KEY_W){1'b0}}, e_word[SW-1 -: KEY_W]};
            end
            S_E_UPD:
            begin
                u_start = estart_reg;
            end
            S_D_CMP:
            begin
                u_key_a = {rule_reg, pid_reg, ekey_reg};
                u_key_b = d_word[DW-1 -: CMP_W];
                u_start = d_word[TIME_W-1:0];
                u_win   = dwin;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        gstart_next = gstart_reg;
        gcount_next = gcount_reg;
        tptr_next   = tptr_reg;
        eptr_next   = eptr_reg;
        dptr_next   = dptr_reg;
        tval_next   = tval_reg;
        evalid_next = evalid_reg;
        dval_next   = dval_reg;
        tsel_next   = tsel_reg;
        esel_next   = esel_reg;
        tstart_next = tstart_reg;
        estart_next = estart_reg;
        tcnt_next   = tcnt_reg;
        ecnt_next   = ecnt_reg;
        tused_next  = tused_reg;
        eused_next  = eused_reg;
        reason_next = reason_reg;
        t_we = 1'b0; t_waddr = tsel_reg; t_wdata = '0;
        e_we = 1'b0; e_waddr = esel_reg; e_wdata = '0;
        d_we = 1'b0; d_waddr = idx_reg[DAW-1:0];
        d_wdata = {rule_reg, pid_reg, ekey_reg, now_reg};
        nstart = '0;
        ncnt   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    tused_next  = 1'b0;
                    eused_next  = 1'b0;
                    reason_next = RSN_NONE;
                    state_next  = S_GLOBAL;
                end
            end
            S_GLOBAL:
            begin
                idx_next = '0;
                ncnt     = gcount_reg;
                if ((gcap_reg != '0) && (now_reg != '0) && expired)
                begin
                    gstart_next = now_reg;
                    gcount_next = '0;
                    ncnt        = '0;
                end
                if ((gcap_reg != '0) && (now_reg != '0) && (ncnt >= gcap_reg))
                begin
                    reason_next = RSN_GLOBAL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = t_en ? S_T_RD : e_en ? S_E_RD : d_en ? S_D_RD : S_COMMIT;
                end
            end
            S_T_RD:
            begin
                state_next = S_T_CMP;
            end
            S_T_CMP:
            begin
                if (u_res.key_eq)
                begin
                    tsel_next   = idx_reg[TAW-1:0];
                    tstart_next = t_word[CAP_W +: TIME_W];
                    tcnt_next   = t_word[CAP_W-1:0];
                    state_next  = S_T_UPD;
                end
                else if (idx_reg == IW'(TENANT_SLOTS - 1))
                begin
                    // miss: take the slot at the pointer, cleared
                    tsel_next   = tptr_reg;
                    tstart_next = '0;
                    tcnt_next   = '0;
                    tptr_next   = (tptr_reg == TAW'(TENANT_SLOTS - 1)) ? '0 : tptr_reg + 1'b1;
                    state_next  = S_T_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_T_RD;
                end
            end
            S_T_UPD:
            begin
                nstart = expired ? now_reg : tstart_reg;
                ncnt   = expired ? '0 : tcnt_reg;
                tstart_next = nstart;
                tcnt_next   = ncnt;
                tused_next  = 1'b1;
                t_we        = 1'b1;
                t_wdata     = {tkey_reg, nstart, ncnt};
                tval_next[tsel_reg] = 1'b1;
                idx_next    = '0;
                if (ncnt >= tcap_reg)
                begin
                    reason_next = RSN_TENANT;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = e_en ? S_E_RD : d_en ? S_D_RD : S_COMMIT;
                end
            end
            S_E_RD:
            begin
                state_next = S_E_CMP;
            end
            S_E_CMP:
            begin
                if (u_res.key_eq)
                begin
                    esel_next   = idx_reg[EAW-1:0];
                    estart_next = e_word[CAP_W +: TIME_W];
                    ecnt_next   = e_word[CAP_W-1:0];
                    state_next  = S_E_UPD;
                end
                else if (idx_reg == IW'(ENDPOINT_SLOTS - 1))
                begin
                    esel_next   = eptr_reg;
                    estart_next = '0;
                    ecnt_next   = '0;
                    eptr_next   = (eptr_reg == EAW'(ENDPOINT_SLOTS - 1)) ? '0 : eptr_reg + 1'b1;
                    state_next  = S_E_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_E_RD;
                end
            end
            S_E_UPD:
            begin
                nstart = expired ? now_reg : estart_reg;
                ncnt   = expired ? '0 : ecnt_reg;
                estart_next = nstart;
                ecnt_next   = ncnt;
                eused_next  = 1'b1;
                e_we        = 1'b1;
                e_wdata     = {ekey_reg, nstart, ncnt};
                evalid_next[esel_reg] = 1'b1;
                idx_next    = '0;
                if (ncnt >= ecap_reg)
                begin
                    reason_next = RSN_ENDPOINT;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = d_en ? S_D_RD : S_COMMIT;
                end
            end
            S_D_RD:
            begin
                state_next = S_D_CMP;
            end
            S_D_CMP:
            begin
                if (u_res.key_eq)
                begin
                    // still inside the cooldown: now below last + window
                    if (u_res.now_lt || !u_res.span_ge)
                    begin
                        reason_next = RSN_DUP;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        d_we    = 1'b1;
                        d_waddr = idx_reg[DAW-1:0];
                        dval_next[idx_reg[DAW-1:0]] = 1'b1;
                        state_next = S_COMMIT;
                    end
                end
                else if (idx_reg == IW'(DEDUP_SLOTS - 1))
                begin
                    d_we      = 1'b1;
                    d_waddr   = dptr_reg;
                    dval_next[dptr_reg] = 1'b1;
                    dptr_next = (dptr_reg == DAW'(DEDUP_SLOTS - 1)) ? '0 : dptr_reg + 1'b1;
                    state_next = S_COMMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_D_RD;
                end
            end
            S_COMMIT:
            begin
                // admitted: bump the counters, saturating at the cap
                if ((gcap_reg != '0) && (gcount_reg < gcap_reg))
                begin
                    gcount_next = gcount_reg + 1'b1;
                end
                if (tused_reg && (tcnt_reg < tcap_reg))
                begin
                    t_we    = 1'b1;
                    t_wdata = {tkey_reg, tstart_reg, tcnt_reg + 1'b1};
                end
                if (eused_reg && (ecnt_reg < ecap_reg))
                begin
                    e_we    = 1'b1;
                    e_wdata = {ekey_reg, estart_reg, ecnt_reg + 1'b1};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            gstart_reg <= '0;
            gcount_reg <= '0;
            tptr_reg   <= '0;
            eptr_reg   <= '0;
            dptr_reg   <= '0;
            tval_reg   <= '0;
            evalid_reg <= '0;
            dval_reg   <= '0;
            trv_reg    <= 1'b0;
            erv_reg    <= 1'b0;
            drv_reg    <= 1'b0;
            tused_reg  <= 1'b0;
            eused_reg  <= 1'b0;
            reason_reg <= RSN_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            gstart_reg <= gstart_next;
            gcount_reg <= gcount_next;
            tptr_reg   <= tptr_next;
            eptr_reg   <= eptr_next;
            dptr_reg   <= dptr_next;
            tval_reg   <= tval_next;
            evalid_reg <= evalid_next;
            dval_reg   <= dval_next;
            trv_reg    <= tval_reg[idx_reg[TAW-1:0]];
            erv_reg    <= evalid_reg[idx_reg[EAW-1:0]];
            drv_reg    <= dval_reg[idx_reg[DAW-1:0]];
            tused_reg  <= tused_next;
            eused_reg  <= eused_next;
            reason_reg <= reason_next;
        end
    end

    // payload: hold the request and the selected slots
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req.valid)
        begin
            rule_reg <= req.rule_key;
            tkey_reg <= req.tenant_key;
            ekey_reg <= req.endpoint_key;
            pid_reg  <= req.process_id;
            now_reg  <= req.now_ms;
        end
        tsel_reg   <= tsel_next;
        esel_reg   <= esel_next;
        tstart_reg <= tstart_next;
        estart_reg <= estart_next;
        tcnt_reg   <= tcnt_next;
        ecnt_reg   <= ecnt_next;
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcap_reg <= RST_GLOBAL_CAP;
            tcap_reg <= RST_TENANT_CAP;
            ecap_reg <= RST_ENDPOINT_CAP;
            dsec_reg <= RST_DEDUP_SECS;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[PADDR_W-1:2]))
                REG_GLOBAL_CAP:   gcap_reg <= pwdata[CAP_W-1:0];
                REG_TENANT_CAP:   tcap_reg <= pwdata[CAP_W-1:0];
                REG_ENDPOINT_CAP: ecap_reg <= pwdata[CAP_W-1:0];
                REG_DEDUP_SECS:   dsec_reg <= pwdata[DSEC_W-1:0];
                default:          gcap_reg <= gcap_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[PADDR_W-1:2]))
            REG_GLOBAL_CAP:   prdata = {{(PDATA_W - CAP_W){1'b0}}, gcap_reg};
            REG_TENANT_CAP:   prdata = {{(PDATA_W - CAP_W){1'b0}}, tcap_reg};
            REG_ENDPOINT_CAP: prdata = {{(PDATA_W - CAP_W){1'b0}}, ecap_reg};
            REG_DEDUP_SECS:   prdata = {{(PDATA_W - DSEC_W){1'b0}}, dsec_reg};
            default:          prdata = '0;
        endcase
    end

    // handshake: take a request only while idle, present the result in done
    assign req.ready        = (state_reg == S_IDLE);
    assign res.valid        = (state_reg == S_DONE);
    assign res.admitted     = (reason_reg == RSN_NONE);
    assign res.block_reason = reason_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !res.valid)
        else $error("request taken while a result is pending");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_GLOBAL))
        else $error("accepted request did not start the global check");
    a_gcount_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_COMMIT) && (gcount_reg >= gcap_reg)) |=> $stable(gcount_reg))
        else $error("global count ran past its cap");
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(tptr_reg) < TENANT_SLOTS) && (32'(eptr_reg) < ENDPOINT_SLOTS)
        && (32'(dptr_reg) < DEDUP_SLOTS))
        else $error("replace pointer out of range");
`endif
endmodule
